>>> rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: label");

`endif

>>> rtl/ddmrc_pkg.sv
package ddmrc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int NUM_LANES   = 2;

  // Exact product, one lane's sum of two products, sum of all lanes.
  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  localparam int LANE_BITS = PROD_BITS + 1;
  localparam int TERM_BITS = PROD_BITS + 2;
  localparam int SUM_BITS  = ((ACC_BITS > TERM_BITS) ? ACC_BITS : TERM_BITS) + 1;

  localparam logic signed [SUM_BITS-1:0] ACC_MAX =
    {{(SUM_BITS - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] ACC_MIN = ~ACC_MAX;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] y1_re;
    logic signed [SAMPLE_BITS-1:0] y1_im;
    logic signed [SAMPLE_BITS-1:0] h1_re;
    logic signed [SAMPLE_BITS-1:0] h1_im;
    logic signed [SAMPLE_BITS-1:0] y2_re;
    logic signed [SAMPLE_BITS-1:0] y2_im;
    logic signed [SAMPLE_BITS-1:0] h2_re;
    logic signed [SAMPLE_BITS-1:0] h2_im;
    logic                          last_antenna;
  } ddmrc_in_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] combined_re;
    logic signed [ACC_BITS-1:0] combined_im;
    logic                       bit_i;
    logic                       bit_q;
  } ddmrc_out_t;

  // Pipeline control from the top level to the merging stage.
  typedef struct packed {
    logic s2_load;
    logic acc_go;
    logic last;
  } ddmrc_ctl_t;

  function automatic logic signed [ACC_BITS-1:0] sat_acc(logic signed [SUM_BITS-1:0] x);
    logic signed [SUM_BITS-1:0] r;
    r = x;
    if (x > ACC_MAX) r = ACC_MAX;
    else if (x < ACC_MIN) r = ACC_MIN;
    return r[ACC_BITS-1:0];
  endfunction

endpackage

>>> rtl/ddmrc_lane.sv
// One slot: y * conj(h), products registered.
module ddmrc_lane import ddmrc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] y_re_i,
  input  logic signed [SAMPLE_BITS-1:0] y_im_i,
  input  logic signed [SAMPLE_BITS-1:0] h_re_i,
  input  logic signed [SAMPLE_BITS-1:0] h_im_i,
  output logic signed [LANE_BITS-1:0]   re_o,
  output logic signed [LANE_BITS-1:0]   im_o
);

  logic signed [PROD_BITS-1:0] rr_q, ii_q, ir_q, ri_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q <= y_re_i * h_re_i;
      ii_q <= y_im_i * h_im_i;
      ir_q <= y_im_i * h_re_i;
      ri_q <= y_re_i * h_im_i;
    end
  end

  assign re_o = LANE_BITS'(rr_q) + LANE_BITS'(ii_q);
  assign im_o = LANE_BITS'(ir_q) - LANE_BITS'(ri_q);

endmodule

>>> rtl/ddmrc_merge.sv
// Merge lane terms, then saturating accumulate and result register.
module ddmrc_merge import ddmrc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ddmrc_ctl_t                  ctl_i,
  input  logic signed [LANE_BITS-1:0] lane_re_i [NUM_LANES],
  input  logic signed [LANE_BITS-1:0] lane_im_i [NUM_LANES],
  output ddmrc_out_t                  out_beat_o
);

  logic signed [TERM_BITS-1:0] term_re_q, term_im_q;
  logic signed [ACC_BITS-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [ACC_BITS-1:0]  sat_re, sat_im;
  ddmrc_out_t                  out_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.s2_load) begin
      term_re_q <= TERM_BITS'(lane_re_i[0]) + TERM_BITS'(lane_re_i[1]);
      term_im_q <= TERM_BITS'(lane_im_i[0]) + TERM_BITS'(lane_im_i[1]);
    end
  end

  always_comb begin
    sat_re   = sat_acc(SUM_BITS'(acc_re_q) + SUM_BITS'(term_re_q));
    sat_im   = sat_acc(SUM_BITS'(acc_im_q) + SUM_BITS'(term_im_q));
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (ctl_i.acc_go) begin
      acc_re_d = ctl_i.last ? '0 : sat_re;
      acc_im_d = ctl_i.last ? '0 : sat_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_go && ctl_i.last) begin
      out_q.combined_re <= sat_re;
      out_q.combined_im <= sat_im;
      out_q.bit_i       <= !sat_re[ACC_BITS-1] && (|sat_re);
      out_q.bit_q       <= !sat_im[ACC_BITS-1] && (|sat_im);
    end
  end

  assign out_beat_o = out_q;

endmodule

>>> rtl/delay_diversity_mrc_combiner_top.sv
// Delay-diversity maximal-ratio combiner with hard QPSK decisions. Send one
// beat per receive antenna, each carrying both slots' samples and channel
// estimates; mark the symbol's final antenna with last_antenna. The block
// sums Re/Im of y1*conj(h1) + y2*conj(h2) over the antennas into 40-bit
// saturating accumulators and, on the last beat, emits the combined symbol
// with its sign decisions, then clears. It takes one beat per cycle unless
// stalled; a result passes the product, merged-term and result registers.
// Each lane has one multiply stage (two lanes, four multipliers each) and
// one saturating accumulator add per cycle. Input stalls only when a last
// beat reaches the accumulator while a previous result is still held.
module delay_diversity_mrc_combiner_top import ddmrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ddmrc_in_t  in_beat_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ddmrc_out_t out_beat_o
);

  `include "assert_macros.svh"

  // Stage valids: s1 = products, s2 = merged term, then result register.
  logic s1_v_q, s1_last_q, s2_v_q, s2_last_q, out_v_q;
  logic out_free, acc_go, s2_ready, s1_ready;
  ddmrc_ctl_t ctl;

  logic signed [LANE_BITS-1:0] lane_re [NUM_LANES];
  logic signed [LANE_BITS-1:0] lane_im [NUM_LANES];

  // Only a last beat needs the output register; others flow past a held result.
  assign out_free = !out_v_q || !out_stall_i;
  assign acc_go   = s2_v_q && (!s2_last_q || out_free);
  assign s2_ready = !s2_v_q || acc_go;
  assign s1_ready = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign ctl.s2_load = s2_ready;
  assign ctl.acc_go  = acc_go;
  assign ctl.last    = s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      // Advance each stage when the one below can take it; otherwise hold.
      if (s1_ready) begin
        s1_v_q    <= in_valid_i;
        s1_last_q <= in_beat_i.last_antenna;
      end
      if (s2_ready) begin
        s2_v_q    <= s1_v_q;
        s2_last_q <= s1_last_q;
      end
      // Raise on a finished symbol, drop once the beat is taken.
      if (acc_go && s2_last_q) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Lane 0 handles the first slot, lane 1 the second.
  ddmrc_lane u_lane0 (
    .clk_i  (clk_i),
    .en_i   (s1_ready),
    .y_re_i (in_beat_i.y1_re),
    .y_im_i (in_beat_i.y1_im),
    .h_re_i (in_beat_i.h1_re),
    .h_im_i (in_beat_i.h1_im),
    .re_o   (lane_re[0]),
    .im_o   (lane_im[0])
  );

  ddmrc_lane u_lane1 (
    .clk_i  (clk_i),
    .en_i   (s1_ready),
    .y_re_i (in_beat_i.y2_re),
    .y_im_i (in_beat_i.y2_im),
    .h_re_i (in_beat_i.h2_re),
    .h_im_i (in_beat_i.h2_im),
    .re_o   (lane_re[1]),
    .im_o   (lane_im[1])
  );

  ddmrc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .lane_re_i  (lane_re),
    .lane_im_i  (lane_im),
    .out_beat_o (out_beat_o)
  );

  assign out_valid_o = out_v_q;

  // Never stall the input while the product stage is empty.
  `ASSERT_IMPLIES(a_stall_needs_s1, clk_i, rst_ni, in_stall_o, s1_v_q)
  // A pending result is never overwritten by the next symbol.
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, out_v_q && out_stall_i,
                  !(acc_go && s2_last_q))
  // A blocked term stage keeps its item and its last mark.
  `ASSERT_NEXT(a_s2_hold, clk_i, rst_ni, s2_v_q && !acc_go,
               s2_v_q && $stable(s2_last_q))

endmodule
